[rtl/pse_pkg.sv]
// Shared types, markers and constants of the token encoder.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  // Token kinds
  localparam logic [3:0] MODE_NULL   = 4'd0;
  localparam logic [3:0] MODE_BOOL   = 4'd1;
  localparam logic [3:0] MODE_INT    = 4'd2;
  localparam logic [3:0] MODE_FLOAT  = 4'd3;
  localparam logic [3:0] MODE_STR    = 4'd4;
  localparam logic [3:0] MODE_LIST   = 4'd5;
  localparam logic [3:0] MODE_MAP    = 4'd6;
  localparam logic [3:0] MODE_STRUCT = 4'd7;
  localparam logic [3:0] MODE_RAW    = 4'd8;

  // Size header families, selected by the low two bits of the kind
  localparam logic [1:0] FAM_STR  = 2'd0;
  localparam logic [1:0] FAM_LIST = 2'd1;
  localparam logic [1:0] FAM_MAP  = 2'd2;

  // Size header forms
  localparam logic [1:0] SZ_TINY = 2'd0;
  localparam logic [1:0] SZ_8    = 2'd1;
  localparam logic [1:0] SZ_16   = 2'd2;
  localparam logic [1:0] SZ_32   = 2'd3;

  localparam logic [7:0] MK_NULL   = 8'hC0;
  localparam logic [7:0] MK_FLOAT  = 8'hC1;
  localparam logic [7:0] MK_FALSE  = 8'hC2;
  localparam logic [7:0] MK_TRUE   = 8'hC3;
  localparam logic [7:0] MK_INT8   = 8'hC8;
  localparam logic [7:0] MK_INT16  = 8'hC9;
  localparam logic [7:0] MK_INT32  = 8'hCA;
  localparam logic [7:0] MK_INT64  = 8'hCB;
  localparam logic [7:0] MK_STRUCT = 8'hB0;

  localparam logic signed [63:0] TINY_INT_MIN = -64'sd16;
  localparam logic signed [63:0] S8_LO        = -64'sd128;
  localparam logic signed [63:0] S8_HI        = 64'sd127;
  localparam logic signed [63:0] S16_LO       = -64'sd32768;
  localparam logic signed [63:0] S16_HI       = 64'sd32767;
  localparam logic signed [63:0] S32_LO       = -64'sd2147483648;
  localparam logic signed [63:0] S32_HI       = 64'sd2147483647;

  localparam logic [31:0] TINY_SIZE_MAX = 32'd15;
  localparam logic [31:0] U8_TOP        = 32'd255;
  localparam logic [31:0] U16_TOP       = 32'd65535;

  // Payload bytes that may follow the head byte
  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned CNT_W = $clog2(MAX_DATA_BYTES + 2);

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [63:0] value_word;
    logic [7:0]         signature;
  } token_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } result_t;

  // Classified token: head byte, left-aligned payload and its length
  typedef struct packed {
    logic [7:0]       head;
    logic [63:0]      data;
    logic [CNT_W-1:0] nbytes;
    logic             error;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] rem;
  } back_status_t;

  function automatic logic [7:0] size_marker(input logic [1:0] fam, input logic [1:0] form);
    logic [7:0] base;
    begin
      case (fam)
        FAM_STR:  base = 8'h80;
        FAM_LIST: base = 8'h90;
        FAM_MAP:  base = 8'hA0;
        default:  base = 8'h80;
      endcase
      case (form)
        SZ_TINY: size_marker = base;
        SZ_8:    size_marker = {4'hD, base[5:4], 2'd0};
        SZ_16:   size_marker = {4'hD, base[5:4], 2'd1};
        SZ_32:   size_marker = {4'hD, base[5:4], 2'd2};
        default: size_marker = base;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

[rtl/pse_front.sv]
// Token classifier: picks the head byte and the payload bytes of each token.
`timescale 1ns / 1ps
`default_nettype none
module pse_front (
  input  pse_pkg::token_t token_i,
  output pse_pkg::cmd_t   cmd_o
);

  logic signed [63:0] w;
  logic [31:0]        sz;
  logic [1:0]         fam;

  assign w   = token_i.value_word;
  assign sz  = w[31:0];
  assign fam = token_i.mode[1:0];

  always_comb begin
    cmd_o = '0;
    case (token_i.mode)
      pse_pkg::MODE_NULL: begin
        cmd_o.head = pse_pkg::MK_NULL;
      end
      pse_pkg::MODE_BOOL: begin
        cmd_o.head = w[0] ? pse_pkg::MK_TRUE : pse_pkg::MK_FALSE;
      end
      pse_pkg::MODE_INT: begin
        // narrowest signed form wins
        if (w >= pse_pkg::TINY_INT_MIN && w <= pse_pkg::S8_HI) begin
          cmd_o.head = w[7:0];
        end else if (w >= pse_pkg::S8_LO && w <= pse_pkg::S8_HI) begin
          cmd_o.head   = pse_pkg::MK_INT8;
          cmd_o.data   = {w[7:0], 56'd0};
          cmd_o.nbytes = pse_pkg::CNT_W'(1);
        end else if (w >= pse_pkg::S16_LO && w <= pse_pkg::S16_HI) begin
          cmd_o.head   = pse_pkg::MK_INT16;
          cmd_o.data   = {w[15:0], 48'd0};
          cmd_o.nbytes = pse_pkg::CNT_W'(2);
        end else if (w >= pse_pkg::S32_LO && w <= pse_pkg::S32_HI) begin
          cmd_o.head   = pse_pkg::MK_INT32;
          cmd_o.data   = {w[31:0], 32'd0};
          cmd_o.nbytes = pse_pkg::CNT_W'(4);
        end else begin
          cmd_o.head   = pse_pkg::MK_INT64;
          cmd_o.data   = w;
          cmd_o.nbytes = pse_pkg::CNT_W'(8);
        end
      end
      pse_pkg::MODE_FLOAT: begin
        cmd_o.head   = pse_pkg::MK_FLOAT;
        cmd_o.data   = w;
        cmd_o.nbytes = pse_pkg::CNT_W'(8);
      end
      pse_pkg::MODE_STR, pse_pkg::MODE_LIST, pse_pkg::MODE_MAP: begin
        if (sz <= pse_pkg::TINY_SIZE_MAX) begin
          cmd_o.head = pse_pkg::size_marker(fam, pse_pkg::SZ_TINY) | {4'd0, sz[3:0]};
        end else if (sz <= pse_pkg::U8_TOP) begin
          cmd_o.head   = pse_pkg::size_marker(fam, pse_pkg::SZ_8);
          cmd_o.data   = {sz[7:0], 56'd0};
          cmd_o.nbytes = pse_pkg::CNT_W'(1);
        end else if (sz <= pse_pkg::U16_TOP) begin
          cmd_o.head   = pse_pkg::size_marker(fam, pse_pkg::SZ_16);
          cmd_o.data   = {sz[15:0], 48'd0};
          cmd_o.nbytes = pse_pkg::CNT_W'(2);
        end else begin
          cmd_o.head   = pse_pkg::size_marker(fam, pse_pkg::SZ_32);
          cmd_o.data   = {sz, 32'd0};
          cmd_o.nbytes = pse_pkg::CNT_W'(4);
        end
      end
      pse_pkg::MODE_STRUCT: begin
        cmd_o.head   = pse_pkg::MK_STRUCT | {4'd0, w[3:0]};
        cmd_o.data   = {token_i.signature, 56'd0};
        cmd_o.nbytes = pse_pkg::CNT_W'(1);
      end
      pse_pkg::MODE_RAW: begin
        cmd_o.head = w[7:0];
      end
      default: begin
        cmd_o.error = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/pse_cmd_fifo.sv]
// Two-entry queue of classified tokens between classifier and serialiser.
`timescale 1ns / 1ps
`default_nettype none
module pse_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  pse_pkg::cmd_t wr_cmd_i,
  input  logic          rd_i,
  output pse_pkg::cmd_t rd_cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  pse_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o   = (cnt_q == 2'd2);
  assign empty_o  = (cnt_q == 2'd0);
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_i;
    rd_ptr_d = rd_ptr_q ^ rd_i;
    cnt_d    = cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/pse_back.sv]
// Byte serialiser: shifts out head and payload bytes into an output register.
`timescale 1ns / 1ps
`default_nettype none
module pse_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pse_pkg::cmd_t         cmd_i,
  input  logic                  cmd_empty_i,
  output logic                  cmd_rd_o,
  output pse_pkg::result_t      result_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output pse_pkg::back_status_t status_o
);

  localparam int unsigned SR_W = 8 * (pse_pkg::MAX_DATA_BYTES + 1);

  logic                     act_q, act_d;
  logic [SR_W-1:0]          sr_q, sr_d;
  logic [pse_pkg::CNT_W-1:0] rem_q, rem_d;
  logic                     err_q, err_d;
  logic                     ovalid_q, ovalid_d;
  pse_pkg::result_t         out_q, out_d;
  logic                     emit, last_byte, load;

  assign emit      = act_q && (!ovalid_q || pop_i);
  assign last_byte = (rem_q == pse_pkg::CNT_W'(1));
  // take the next token once the current one has sent its final byte
  assign load      = (!act_q || (emit && last_byte)) && !cmd_empty_i;
  assign cmd_rd_o  = load;

  always_comb begin
    act_d    = act_q;
    sr_d     = sr_q;
    rem_d    = rem_q;
    err_d    = err_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    if (pop_i && ovalid_q) begin
      ovalid_d = 1'b0;
    end
    if (emit) begin
      ovalid_d       = 1'b1;
      out_d.out_byte = sr_q[SR_W-1 -: 8];
      out_d.last     = last_byte;
      out_d.error    = err_q;
      sr_d           = {sr_q[SR_W-9:0], 8'd0};
      rem_d          = rem_q - pse_pkg::CNT_W'(1);
      if (last_byte) begin
        act_d = 1'b0;
      end
    end
    if (load) begin
      act_d = 1'b1;
      sr_d  = {cmd_i.head, cmd_i.data};
      rem_d = cmd_i.nbytes + pse_pkg::CNT_W'(1);
      err_d = cmd_i.error;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign result_o      = out_q;
  assign empty_o       = !ovalid_q;
  assign status_o.busy = act_q;
  assign status_o.rem  = rem_q;

endmodule
`default_nettype wire

[rtl/packstream_token_encoder_core.sv]
// Top level of the token encoder: classifier, command queue and byte serialiser.
//
//   channel   direction  handshake          payload
//   token     in         push_i / full_o    token_i  (mode, value_word, signature)
//   result    out        pop_i  / empty_o   result_o (out_byte, last, error)
//
// A token yields 1 to 9 bytes and the serialiser sends one byte a cycle while the receiver
// keeps popping; one-byte tokens then flow at one a cycle.
// A token passes the command queue, the shift register and the output register before result_o.
// The two-entry command queue lets tokens enter while earlier ones are still being sent.
// Reset empties both sides; a stalled result holds while the queue keeps filling.
`timescale 1ns / 1ps
`default_nettype none
module packstream_token_encoder_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  pse_pkg::token_t  token_i,
  input  logic             pop_i,
  output logic             empty_o,
  output pse_pkg::result_t result_o
);

  pse_pkg::cmd_t         front_cmd;
  pse_pkg::cmd_t         q_cmd;
  logic                  q_wr, q_rd, q_full, q_empty;
  pse_pkg::back_status_t back_st;

  assign full_o = q_full;
  assign q_wr   = push_i && !q_full;

  pse_front u_front (
    .token_i (token_i),
    .cmd_o   (front_cmd)
  );

  pse_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_cmd_i (front_cmd),
    .rd_i     (q_rd),
    .rd_cmd_o (q_cmd),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  pse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_empty_i (q_empty),
    .cmd_rd_o    (q_rd),
    .result_o    (result_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .status_o    (back_st)
  );

  // an error result is a lone zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.error) |-> (result_o.last && result_o.out_byte == 8'd0))
    else $error("error result not a single zero byte");

  // the serialiser never reads an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty)
    else $error("command read from empty queue");

  // an active token always has bytes left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.busy |-> (back_st.rem != '0 && back_st.rem <= pse_pkg::CNT_W'(9)))
    else $error("serialiser byte count out of range");

  // a popped non-final byte is followed by more bytes of the same token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !result_o.last) |=> back_st.busy || !empty_o)
    else $error("token ended without a final byte");

endmodule
`default_nettype wire

[tb/tb_packstream_token_encoder_core.sv]
// Self-checking testbench of the token encoder: directed and random tokens, byte-level checks.
`timescale 1ns / 1ps
module tb_packstream_token_encoder_core;

  localparam logic [7:0] HDR_NULL   = 8'hC0;
  localparam logic [7:0] HDR_FLOAT  = 8'hC1;
  localparam logic [7:0] HDR_FALSE  = 8'hC2;
  localparam logic [7:0] HDR_TRUE   = 8'hC3;
  localparam logic [7:0] HDR_INT8   = 8'hC8;
  localparam logic [7:0] HDR_INT16  = 8'hC9;
  localparam logic [7:0] HDR_INT32  = 8'hCA;
  localparam logic [7:0] HDR_INT64  = 8'hCB;
  localparam logic [7:0] HDR_STRUCT = 8'hB0;
  localparam logic [7:0] TINY_STR   = 8'h80;
  localparam logic [7:0] TINY_LIST  = 8'h90;
  localparam logic [7:0] TINY_MAP   = 8'hA0;
  localparam logic [7:0] LONG_STR   = 8'hD0;
  localparam logic [7:0] LONG_LIST  = 8'hD4;
  localparam logic [7:0] LONG_MAP   = 8'hD8;
  localparam logic [3:0] MODE_BAD_LO = 4'd9;
  localparam logic [3:0] MODE_BAD_HI = 4'd15;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push_i;
  logic              full_o;
  pse_pkg::token_t   token_i;
  logic              pop_i;
  logic              empty_o;
  pse_pkg::result_t  result_o;

  pse_pkg::result_t  pending_bytes [$];
  int                mismatch_cnt = 0;
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                hold_left = 0;

  packstream_token_encoder_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .token_i  (token_i),
    .pop_i    (pop_i),
    .empty_o  (empty_o),
    .result_o (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Work out the byte sequence of one token and queue it as expected results
  function automatic void encode_token(input pse_pkg::token_t tok);
    logic signed [63:0] v;
    logic [31:0]        sz;
    logic [63:0]        payload;
    logic [7:0]         head;
    logic [7:0]         tiny;
    logic [7:0]         long_hdr;
    int                 k;
    pse_pkg::result_t   r;
    begin
      v = tok.value_word;
      sz = v[31:0];
      payload = '0;
      head = 8'h00;
      k = 0;
      tiny = TINY_STR;
      long_hdr = LONG_STR;
      case (tok.mode)
        pse_pkg::MODE_NULL: head = HDR_NULL;
        pse_pkg::MODE_BOOL: head = v[0] ? HDR_TRUE : HDR_FALSE;
        pse_pkg::MODE_INT: begin
          payload = v;
          if (v >= -16 && v <= 127) begin
            head = v[7:0];
          end else if (v >= -128 && v <= 127) begin
            head = HDR_INT8;
            k = 1;
          end else if (v >= -32768 && v <= 32767) begin
            head = HDR_INT16;
            k = 2;
          end else if (v >= -64'sd2147483648 && v <= 64'sd2147483647) begin
            head = HDR_INT32;
            k = 4;
          end else begin
            head = HDR_INT64;
            k = 8;
          end
        end
        pse_pkg::MODE_FLOAT: begin
          head = HDR_FLOAT;
          payload = v;
          k = 8;
        end
        pse_pkg::MODE_STR, pse_pkg::MODE_LIST, pse_pkg::MODE_MAP: begin
          if (tok.mode == pse_pkg::MODE_LIST) begin
            tiny = TINY_LIST;
            long_hdr = LONG_LIST;
          end else if (tok.mode == pse_pkg::MODE_MAP) begin
            tiny = TINY_MAP;
            long_hdr = LONG_MAP;
          end
          payload = {32'h0, sz};
          if (sz <= 32'd15) begin
            head = tiny + sz[7:0];
          end else if (sz <= 32'd255) begin
            head = long_hdr;
            k = 1;
          end else if (sz <= 32'd65535) begin
            head = long_hdr + 8'd1;
            k = 2;
          end else begin
            head = long_hdr + 8'd2;
            k = 4;
          end
        end
        pse_pkg::MODE_STRUCT: begin
          head = HDR_STRUCT + {4'h0, v[3:0]};
          payload = {56'h0, tok.signature};
          k = 1;
        end
        pse_pkg::MODE_RAW: head = v[7:0];
        default: begin
          r.out_byte = 8'h00;
          r.last = 1'b1;
          r.error = 1'b1;
          pending_bytes.push_back(r);
          return;
        end
      endcase
      r.out_byte = head;
      r.last = (k == 0);
      r.error = 1'b0;
      pending_bytes.push_back(r);
      for (int i = k - 1; i >= 0; i--) begin
        r.out_byte = payload[8*i +: 8];
        r.last = (i == 0);
        r.error = 1'b0;
        pending_bytes.push_back(r);
      end
    end
  endfunction

  function automatic pse_pkg::token_t mk_tok(input logic [3:0] mode, input logic [63:0] val,
                                             input logic [7:0] sig);
    pse_pkg::token_t t;
    begin
      t.mode = mode;
      t.value_word = val;
      t.signature = sig;
      return t;
    end
  endfunction

  // Random token, biased towards the range boundaries of each form
  function automatic pse_pkg::token_t rand_token();
    pse_pkg::token_t    t;
    logic signed [63:0] v;
    int                 r;
    begin
      r = $urandom_range(99);
      if (r < 8) t.mode = 4'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
      else if (r < 40) t.mode = pse_pkg::MODE_INT;
      else t.mode = 4'($urandom_range(pse_pkg::MODE_RAW, pse_pkg::MODE_NULL));
      v = {$urandom, $urandom};
      case ($urandom_range(3))
        0: ;
        1: v = v >>> $urandom_range(63);
        2: begin
          case ($urandom_range(6))
            0: v = -16;
            1: v = 127;
            2: v = -128;
            3: v = 32767;
            4: v = -32768;
            5: v = 64'sd2147483647;
            default: v = -64'sd2147483648;
          endcase
          v = v + $signed($urandom_range(2)) - 1;
        end
        default: v = v >>> $urandom_range(63, 56);
      endcase
      // Sizes only look at the low word: spread its magnitude
      if (t.mode == pse_pkg::MODE_STR || t.mode == pse_pkg::MODE_LIST ||
          t.mode == pse_pkg::MODE_MAP)
        v[31:0] = $urandom >> $urandom_range(31);
      t.value_word = v;
      t.signature = 8'($urandom);
      return t;
    end
  endfunction

  // Offer one token until it is taken, with random gaps beforehand
  task automatic send_token(input pse_pkg::token_t tok);
    begin
      while ($urandom_range(99) < gap_pct) begin
        push_i <= 1'b0;
        @(posedge clk_i);
      end
      push_i <= 1'b1;
      token_i <= tok;
      do @(posedge clk_i); while (full_o);
      encode_token(tok);
    end
  endtask

  task automatic run_random(input int n);
    begin
      repeat (n) send_token(rand_token());
    end
  endtask

  task automatic test_directed();
    begin
      gap_pct = 0;
      stall_pct = 0;
      send_token(mk_tok(pse_pkg::MODE_NULL, 64'h0, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF));
      send_token(mk_tok(pse_pkg::MODE_BOOL, 64'h8000_0000_0000_0001, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, -64'sd16, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, -64'sd17, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, 64'sd127, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, 64'sd128, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, -64'sd129, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, 64'sd32768, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, -64'sd32769, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, 64'sd2147483648, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, -64'sd2147483649, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, 64'h8000_0000_0000_0000, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_INT, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_FLOAT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_STR, 64'hFFFF_FFFF_0000_000F, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_STR, 64'h0000_0000_0000_0010, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_LIST, 64'h0000_0000_0000_00FF, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_LIST, 64'h0000_0000_0000_0100, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_MAP, 64'h0000_0000_0000_FFFF, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_MAP, 64'h0000_0000_0001_0000, 8'h00));
      send_token(mk_tok(pse_pkg::MODE_MAP, 64'h1234_5678_FFFF_FFFF, 8'h00));
      // field count wraps to its low nibble
      send_token(mk_tok(pse_pkg::MODE_STRUCT, 64'hFFFF_FFFF_FFFF_FF1F, 8'hFF));
      send_token(mk_tok(pse_pkg::MODE_RAW, 64'hFFFF_FFFF_FFFF_FFA5, 8'h00));
      send_token(mk_tok(MODE_BAD_LO, 64'h0, 8'h00));
      send_token(mk_tok(MODE_BAD_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
    end
  endtask

  task automatic test_streaming();
    begin
      gap_pct = 0;
      stall_pct = 0;
      run_random(30);
    end
  endtask

  task automatic test_sender_gaps();
    begin
      gap_pct = 53;
      stall_pct = 0;
      run_random(45);
    end
  endtask

  task automatic test_receiver_stalls();
    begin
      gap_pct = 0;
      stall_pct = 53;
      run_random(45);
    end
  endtask

  task automatic test_both_idle();
    begin
      gap_pct = 22;
      stall_pct = 22;
      run_random(45);
    end
  endtask

  // Hold the receiver off while tokens keep coming, so the input stalls
  task automatic test_backpressure();
    begin
      gap_pct = 0;
      stall_pct = 0;
      hold_left = HOLD_CYCLES;
      run_random(40);
    end
  endtask

  task automatic finish_run();
    begin
      push_i <= 1'b0;
      stall_pct = 0;
      while (pending_bytes.size() != 0) @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
      $finish;
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each transfer on the result side with the oldest expectation
  always @(posedge clk_i) begin
    pse_pkg::result_t exp_r;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h last %b error %b",
                 $time, result_o.out_byte, result_o.last, result_o.error);
        mismatch_cnt++;
      end else begin
        exp_r = pending_bytes.pop_front();
        if (result_o.out_byte !== exp_r.out_byte) begin
          $display("%0t: out_byte mismatch, expected %h actual %h",
                   $time, exp_r.out_byte, result_o.out_byte);
          mismatch_cnt++;
        end
        if (result_o.last !== exp_r.last) begin
          $display("%0t: last mismatch, expected %b actual %b",
                   $time, exp_r.last, result_o.last);
          mismatch_cnt++;
        end
        if (result_o.error !== exp_r.error) begin
          $display("%0t: error mismatch, expected %b actual %b",
                   $time, exp_r.error, result_o.error);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    push_i = 1'b0;
    token_i = '0;
    pop_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    finish_run();
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
